// ===== design/run_length_trace_ring_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Run-length trace ring: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_TRACE_RING_UNIT_DEFINES_SVH
`define RUN_LENGTH_TRACE_RING_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RLTR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("run_length_trace_ring_unit: assertion failed");

// Next-cycle implication.
`define RLTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("run_length_trace_ring_unit: assertion failed");

`endif

// ===== design/rltr_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length trace ring package
// Field widths, entry layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package rltr_pkg;

    localparam int KIND_W  = 3;
    localparam int ARG_W   = 32;
    localparam int SARG_W  = 8;
    localparam int CNT_W   = 16;
    localparam int OFF_W   = 9;
    localparam int ENTRY_W = KIND_W + ARG_W + SARG_W + CNT_W;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ARG_W-1:0]  arg;
        logic [SARG_W-1:0] sarg;
        logic [CNT_W-1:0]  count;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_ADDR,
        ST_RDATA
    } t_state;

endpackage

// ===== design/rltr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rltr_ram #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/run_length_trace_ring_unit.sv =====
// ----------------------------------------------------------------------------
// Run-length trace ring unit
// Event trace ring buffer that merges runs of identical events into a count.
// ----------------------------------------------------------------------------
// Each item is either a record (operation 0) or a read (operation 1) and
// produces exactly one result, shown for one cycle with o_strobe; the
// receiver cannot stall, so capture it when the strobe is high. An item is
// taken when start is high and busy is low. A record compares its event with
// the entry at the current slot: equal means the entry's 16-bit count goes up
// by one (wrapping), otherwise the slot advances modulo DEPTH and a fresh
// entry with count 1 is written there. A read returns the entry read_offset
// places after the oldest slot (the one after the current slot), wrapping
// modulo DEPTH. A record is a read-modify-write of the entry store, whose
// read data is registered: after accept it holds busy in ST_RMW, and the
// result is shown on the return to idle; the next item can be taken in the
// cycle the result is shown. A read passes through ST_DIV, which reduces the
// offset modulo DEPTH with a registered reciprocal multiply, ST_ADDR, which
// reads the store, and ST_RDATA, then shows its result on the return to
// idle. The store needs no clearing pass after reset: written slots are
// tracked from the current slot, a wrap flag and a slot-0 flag, and an
// unwritten slot reads as all zero, so the block is ready out of reset.
// ----------------------------------------------------------------------------
module run_length_trace_ring_unit #(
    parameter int DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic [rltr_pkg::KIND_W-1:0] i_event_type,
    input  logic [rltr_pkg::ARG_W-1:0]  i_event_arg,
    input  logic [rltr_pkg::SARG_W-1:0] i_event_small,
    input  logic [rltr_pkg::OFF_W-1:0]  i_read_offset,
    output logic                       o_strobe,
    output logic [$clog2(DEPTH)-1:0]   o_slot_index,
    output logic                       o_merged,
    output logic [rltr_pkg::KIND_W-1:0] o_entry_type,
    output logic [rltr_pkg::ARG_W-1:0]  o_entry_arg,
    output logic [rltr_pkg::SARG_W-1:0] o_entry_small,
    output logic [rltr_pkg::CNT_W-1:0]  o_entry_count
);

`include "run_length_trace_ring_unit_defines.svh"

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int OFF_W  = rltr_pkg::OFF_W;
    localparam int SUM_W  = ((SLOT_W > OFF_W) ? SLOT_W : OFF_W) + 1;
    localparam int QD_W   = OFF_W + SLOT_W + 1;

    // offset / DEPTH as (offset * DIV_M) >> DIV_S, exact for all 9-bit offsets
    localparam int              DIV_S  = OFF_W + SLOT_W;
    localparam longint unsigned DIV_MV = (64'd1 << DIV_S) / DEPTH + 64'd1;
    localparam int              M_W    = OFF_W + 2;
    localparam int              PROD_W = OFF_W + M_W;
    localparam logic [M_W-1:0]  DIV_M  = M_W'(DIV_MV);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    // ---------------- state ----------------
    rltr_pkg::t_state r_state, n_state;

    logic [SLOT_W-1:0] r_cur, n_cur;         // current slot
    logic              r_wrapped, n_wrapped; // every slot has been written
    logic              r_zero_wr, n_zero_wr; // slot 0 has been written

    // captured item
    logic                         r_op;
    rltr_pkg::t_entry             r_ev;      // count unused
    logic [OFF_W-1:0]             r_offset;
    logic [OFF_W-1:0]             r_quot;
    logic [SLOT_W-1:0]            r_rd_addr;

    // result registers
    logic                         r_strobe, n_strobe;
    logic [SLOT_W-1:0]            r_slot, n_slot;
    logic                         r_merged, n_merged;
    rltr_pkg::t_entry             r_res, n_res;

    // ---------------- datapath wires ----------------
    logic                         w_accept;
    logic [SLOT_W-1:0]            w_next_slot;
    logic [PROD_W-1:0]            w_prod;
    logic [QD_W-1:0]              w_qd;
    logic [OFF_W-1:0]             w_rem;
    logic [SUM_W-1:0]             w_sum;
    logic [SLOT_W-1:0]            w_read_slot;
    logic                         w_entry_valid;
    rltr_pkg::t_entry             w_raw, w_entry, w_wdata;
    logic                         w_match;
    logic                         w_we, w_re;
    logic [SLOT_W-1:0]            w_waddr, w_raddr;
    logic [rltr_pkg::ENTRY_W-1:0] w_rdata;

    assign busy     = (r_state != rltr_pkg::ST_IDLE);
    assign w_accept = start && !busy;

    assign w_next_slot = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;

    // read slot: (cur + 1 + offset mod DEPTH) mod DEPTH, both terms below DEPTH
    assign w_prod      = PROD_W'(r_offset) * PROD_W'(DIV_M);
    assign w_qd        = QD_W'(r_quot) * QD_W'(DEPTH);
    assign w_rem       = r_offset - w_qd[OFF_W-1:0];
    assign w_sum       = SUM_W'(w_next_slot) + SUM_W'(w_rem);
    assign w_read_slot = (w_sum >= SUM_W'(DEPTH)) ? SLOT_W'(w_sum - SUM_W'(DEPTH))
                                                  : SLOT_W'(w_sum);

    // written slots: 1..cur, slot 0 once touched, everything after a wrap
    always_comb begin
        if (r_wrapped) begin
            w_entry_valid = 1'b1;
        end else if (r_rd_addr == '0) begin
            w_entry_valid = r_zero_wr;
        end else begin
            w_entry_valid = (r_rd_addr <= r_cur);
        end
    end

    assign w_raw   = rltr_pkg::t_entry'(w_rdata);
    assign w_entry = w_entry_valid ? w_raw : '0;
    assign w_match = (w_entry.kind == r_ev.kind) && (w_entry.arg == r_ev.arg)
                  && (w_entry.sarg == r_ev.sarg);

    // ---------------- entry store ----------------
    rltr_ram #(
        .WIDTH (rltr_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_wrapped = r_wrapped;
        n_zero_wr = r_zero_wr;
        n_strobe  = 1'b0;
        n_slot    = r_slot;
        n_merged  = r_merged;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_cur;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = r_cur;

        case (r_state)
            rltr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == rltr_pkg::OP_RECORD) begin
                        // fetch current entry for compare
                        w_re    = 1'b1;
                        n_state = rltr_pkg::ST_RMW;
                    end else begin
                        n_state = rltr_pkg::ST_DIV;
                    end
                end
            end
            rltr_pkg::ST_RMW: begin
                w_we = 1'b1;
                if (w_match) begin
                    w_waddr       = r_cur;
                    w_wdata       = w_entry;
                    w_wdata.count = w_entry.count + 1'b1;
                    n_merged      = 1'b1;
                end else begin
                    w_waddr       = w_next_slot;
                    w_wdata       = r_ev;
                    w_wdata.count = rltr_pkg::CNT_W'(1);
                    n_merged      = 1'b0;
                    n_cur         = w_next_slot;
                    if (r_cur == LAST_SLOT) begin
                        n_wrapped = 1'b1;
                    end
                end
                if (w_waddr == '0) begin
                    n_zero_wr = 1'b1;
                end
                n_slot   = w_waddr;
                n_res    = w_wdata;
                n_strobe = 1'b1;
                n_state  = rltr_pkg::ST_IDLE;
            end
            rltr_pkg::ST_DIV: begin
                n_state = rltr_pkg::ST_ADDR;
            end
            rltr_pkg::ST_ADDR: begin
                w_re    = 1'b1;
                w_raddr = w_read_slot;
                n_state = rltr_pkg::ST_RDATA;
            end
            rltr_pkg::ST_RDATA: begin
                n_slot   = r_rd_addr;
                n_merged = 1'b0;
                n_res    = w_entry;
                n_strobe = 1'b1;
                n_state  = rltr_pkg::ST_IDLE;
            end
            default: begin
                n_state = rltr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rltr_pkg::ST_IDLE;
            r_cur     <= '0;
            r_wrapped <= 1'b0;
            r_zero_wr <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_wrapped <= n_wrapped;
            r_zero_wr <= n_zero_wr;
            r_strobe  <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op          <= i_operation;
            r_ev.kind     <= i_event_type;
            r_ev.arg      <= i_event_arg;
            r_ev.sarg     <= i_event_small;
            r_ev.count    <= '0;
            r_offset      <= i_read_offset;
        end
        if (r_state == rltr_pkg::ST_DIV) begin
            r_quot <= OFF_W'(w_prod >> DIV_S);
        end
        if (w_re) begin
            r_rd_addr <= w_raddr;
        end
        r_slot   <= n_slot;
        r_merged <= n_merged;
        r_res    <= n_res;
    end

    assign o_strobe      = r_strobe;
    assign o_slot_index  = r_slot;
    assign o_merged      = r_merged;
    assign o_entry_type  = r_res.kind;
    assign o_entry_arg   = r_res.arg;
    assign o_entry_small = r_res.sarg;
    assign o_entry_count = r_res.count;

    // ---------------- assertions ----------------
    // an accepted item is always followed by busy
    `RLTR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)
    // results never come back to back
    `RLTR_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_strobe, !o_strobe)
    // a merge reports the current slot, which it does not move
    `RLTR_ASSERT_SAME(a_merge_slot, i_clk, i_rst_n, o_strobe && o_merged,
                      o_slot_index == r_cur)
    // a record result follows its write-back stage, tagged by operation
    `RLTR_ASSERT_NEXT(a_rmw_result, i_clk, i_rst_n, r_state == rltr_pkg::ST_RMW,
                      o_strobe && (r_op == rltr_pkg::OP_RECORD))

endmodule

// ===== dv/run_length_trace_ring_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-length trace ring checker
// Predicts each result from a private copy of the ring when an item is taken,
// then compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module run_length_trace_ring_checker #(
    parameter int DEPTH = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_operation,
    input  logic [rltr_pkg::KIND_W-1:0] i_event_type,
    input  logic [rltr_pkg::ARG_W-1:0]  i_event_arg,
    input  logic [rltr_pkg::SARG_W-1:0] i_event_small,
    input  logic [rltr_pkg::OFF_W-1:0]  i_read_offset,
    input  logic                        i_strobe,
    input  logic [$clog2(DEPTH)-1:0]    i_slot_index,
    input  logic                        i_merged,
    input  logic [rltr_pkg::KIND_W-1:0] i_entry_type,
    input  logic [rltr_pkg::ARG_W-1:0]  i_entry_arg,
    input  logic [rltr_pkg::SARG_W-1:0] i_entry_small,
    input  logic [rltr_pkg::CNT_W-1:0]  i_entry_count,
    output int                          o_errors,
    output int                          o_pending
);
    import rltr_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              merged;
        t_entry            entry;
    } trace_result_t;

    t_entry            ring [DEPTH];
    logic [SLOT_W-1:0] newest_slot;
    trace_result_t     expected_results [$];
    int                mismatches = 0;

    // Applies one item to the ring copy and returns the result it must give.
    function automatic trace_result_t apply_trace_item(
        input logic              op,
        input logic [KIND_W-1:0] ev_kind,
        input logic [ARG_W-1:0]  ev_arg,
        input logic [SARG_W-1:0] ev_sarg,
        input logic [OFF_W-1:0]  rd_offset
    );
        trace_result_t res;
        int            pos;
        res.merged = 1'b0;
        if (op == OP_READ) begin
            // oldest slot is the one after the newest; wraps around the ring
            pos       = (int'(newest_slot) + 1 + int'(rd_offset)) % DEPTH;
            res.slot  = pos[SLOT_W-1:0];
            res.entry = ring[pos];
        end else if (ring[newest_slot].kind == ev_kind && ring[newest_slot].arg == ev_arg
                     && ring[newest_slot].sarg == ev_sarg) begin
            ring[newest_slot].count = ring[newest_slot].count + 1'b1;
            res.slot   = newest_slot;
            res.merged = 1'b1;
            res.entry  = ring[newest_slot];
        end else begin
            pos         = (int'(newest_slot) + 1) % DEPTH;
            newest_slot = pos[SLOT_W-1:0];
            ring[newest_slot].kind  = ev_kind;
            ring[newest_slot].arg   = ev_arg;
            ring[newest_slot].sarg  = ev_sarg;
            ring[newest_slot].count = CNT_W'(1);
            res.slot  = newest_slot;
            res.entry = ring[newest_slot];
        end
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        trace_result_t want;
        if (!i_rst_n) begin
            foreach (ring[k]) ring[k] = '0;
            newest_slot = '0;
            expected_results.delete();
        end else begin
            // results leave before a new item joins the queue in the same cycle
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item pending, slot 0x%0h", $time,
                             i_slot_index);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("slot_index",  64'(want.slot),        64'(i_slot_index));
                    compare_field("merged",      64'(want.merged),      64'(i_merged));
                    compare_field("entry_type",  64'(want.entry.kind),  64'(i_entry_type));
                    compare_field("entry_arg",   64'(want.entry.arg),   64'(i_entry_arg));
                    compare_field("entry_small", 64'(want.entry.sarg),  64'(i_entry_small));
                    compare_field("entry_count", 64'(want.entry.count), 64'(i_entry_count));
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(apply_trace_item(i_operation, i_event_type,
                    i_event_arg, i_event_small, i_read_offset));
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule

// ===== dv/run_length_trace_ring_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-length trace ring unit testbench
// Directed corner items, a long merge run on one entry, then random record
// and read traffic with bursty gaps; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module run_length_trace_ring_unit_test;
    import rltr_pkg::*;

    localparam int DEPTH        = 512;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 1400;
    localparam int MERGE_RUN    = 40;    // repeats of one event in a row
    localparam int CALM_TAIL    = 200;   // final random items sent back to back
    localparam int STALL_LIMIT  = 2000;  // cycles with no item in or out
    localparam int DRAIN_CYCLES = 8;     // extra wait once the sender has drained

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic                i_operation   = OP_RECORD;
    logic [KIND_W-1:0]   i_event_type  = '0;
    logic [ARG_W-1:0]    i_event_arg   = '0;
    logic [SARG_W-1:0]   i_event_small = '0;
    logic [OFF_W-1:0]    i_read_offset = '0;
    logic                o_strobe;
    logic [SLOT_W-1:0]   o_slot_index;
    logic                o_merged;
    logic [KIND_W-1:0]   o_entry_type;
    logic [ARG_W-1:0]    o_entry_arg;
    logic [SARG_W-1:0]   o_entry_small;
    logic [CNT_W-1:0]    o_entry_count;
    int                  errors;
    int                  pending;

    // last event recorded: repeating it always merges into the newest slot
    logic [KIND_W-1:0]   last_kind = '0;
    logic [ARG_W-1:0]    last_arg  = '0;
    logic [SARG_W-1:0]   last_sarg = '0;

    run_length_trace_ring_unit #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_event_type  (i_event_type),
        .i_event_arg   (i_event_arg),
        .i_event_small (i_event_small),
        .i_read_offset (i_read_offset),
        .o_strobe      (o_strobe),
        .o_slot_index  (o_slot_index),
        .o_merged      (o_merged),
        .o_entry_type  (o_entry_type),
        .o_entry_arg   (o_entry_arg),
        .o_entry_small (o_entry_small),
        .o_entry_count (o_entry_count)
    );

    run_length_trace_ring_checker #(.DEPTH(DEPTH)) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_event_type  (i_event_type),
        .i_event_arg   (i_event_arg),
        .i_event_small (i_event_small),
        .i_read_offset (i_read_offset),
        .i_strobe      (o_strobe),
        .i_slot_index  (o_slot_index),
        .i_merged      (o_merged),
        .i_entry_type  (o_entry_type),
        .i_entry_arg   (o_entry_arg),
        .i_entry_small (o_entry_small),
        .i_entry_count (o_entry_count),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drives one item and returns at the edge that takes it (start high,
    // busy low). start stays high so the next call can follow at once.
    task automatic issue_item(input logic op, input logic [KIND_W-1:0] kind,
                              input logic [ARG_W-1:0] arg, input logic [SARG_W-1:0] sarg,
                              input logic [OFF_W-1:0] offset);
        start         <= 1'b1;
        i_operation   <= op;
        i_event_type  <= kind;
        i_event_arg   <= arg;
        i_event_small <= sarg;
        i_read_offset <= offset;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Record; the offset field is ignored by the block, so it carries noise.
    task automatic record_event(input logic [KIND_W-1:0] kind, input logic [ARG_W-1:0] arg,
                                input logic [SARG_W-1:0] sarg);
        last_kind = kind;
        last_arg  = arg;
        last_sarg = sarg;
        issue_item(OP_RECORD, kind, arg, sarg, OFF_W'($urandom));
    endtask

    // Read; event fields are ignored, so they carry noise.
    task automatic read_entry(input logic [OFF_W-1:0] offset);
        issue_item(OP_READ, KIND_W'($urandom), $urandom, SARG_W'($urandom), offset);
    endtask

    // Sender holds off until every predicted result has been seen. The first
    // edge lets the checker count the item taken just before.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Ends the run if nothing moves in either direction for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [KIND_W-1:0] kind;
        logic [ARG_W-1:0]  arg;
        logic [SARG_W-1:0] sarg;
        logic [OFF_W-1:0]  offset;
        int                pick;
        bit                bursty;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed corners ----
        read_entry('0);                       // blank slot right after reset
        read_entry('1);                       // wraps back onto slot 0
        record_event('0, '0, '0);             // all-zero event merges into blank slot 0
        record_event('0, '0, '0);             // ... and again, count 2
        record_event('1, '1, '1);             // all ones, new slot
        record_event('1, '1, '1);             // merge
        record_event('1, '1, 8'hFE);          // only small differs -> new slot
        record_event('1, 32'hFFFF_FFFE, 8'hFE); // only arg differs
        record_event(3'd6, 32'hFFFF_FFFE, 8'hFE); // only type differs
        record_event('0, '0, '0);             // blank-looking event, new slot
        read_entry('0);                       // oldest slot, still blank
        read_entry('1);                       // newest slot
        read_entry(OFF_W'(256));
        issue_item(OP_READ, '1, '1, '1, OFF_W'(507)); // event fields set but ignored
        issue_item(OP_RECORD, 3'd1, 32'h8000_0000, 8'h80, '1); // offset ignored
        record_event(3'd1, 32'h0000_0001, 8'h01);
        read_entry('1);

        // ---- long merge run on one entry ----
        wait_results_drained();
        record_event(3'd6, 32'h1234_5678, 8'h9A);
        record_event(3'd5, 32'hA5A5_0001, 8'h3C);
        for (int k = 0; k < MERGE_RUN; k++) record_event(3'd5, 32'hA5A5_0001, 8'h3C);
        read_entry('1);
        record_event(3'd5, 32'hA5A5_0001, 8'h3C);

        // ---- random traffic ----
        bursty = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // bursty or smooth stretches are picked at random; the tail runs flat out
            if (n % 64 == 0) bursty = 1'($urandom_range(0, 1));
            if (bursty && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS / 2) wait_results_drained();

            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 5))
                    0:       offset = '0;
                    1:       offset = '1;
                    default: offset = OFF_W'($urandom);
                endcase
                read_entry(offset);
            end else if (pick < 60) begin
                record_event(last_kind, last_arg, last_sarg);
            end else begin
                // narrow pools now and then so near-misses and zeros show up
                kind = KIND_W'($urandom_range(0, 7));
                case ($urandom_range(0, 3))
                    0:       arg = ARG_W'($urandom_range(0, 3));
                    1:       arg = $urandom_range(0, 1) ? '1 : '0;
                    default: arg = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       sarg = SARG_W'($urandom_range(0, 3));
                    1:       sarg = $urandom_range(0, 1) ? '1 : '0;
                    default: sarg = SARG_W'($urandom);
                endcase
                record_event(kind, arg, sarg);
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
